/* src/atc_pkg.sv */
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, codes and constants of the ANSI text console.
// ----------------------------------------------------------------------------
package atc_pkg;

   localparam logic [2:0] FUNC_PUT = 3'd0;
   localparam logic [2:0] FUNC_X   = 3'd1;
   localparam logic [2:0] FUNC_Y   = 3'd2;
   localparam logic [2:0] FUNC_FG  = 3'd3;
   localparam logic [2:0] FUNC_BG  = 3'd4;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_LBR  = 8'h5B;
   localparam logic [7:0] CH_SGR  = 8'h6D;
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_SEQ    = 2'd2;

   localparam logic [2:0] REG_FONT_W = 3'd0;
   localparam logic [2:0] REG_FONT_H = 3'd1;
   localparam logic [2:0] REG_SCR_W  = 3'd2;
   localparam logic [2:0] REG_SCR_H  = 3'd3;
   localparam logic [2:0] REG_DEF_FG = 3'd4;
   localparam logic [2:0] REG_DEF_BG = 3'd5;

   localparam logic [6:0]  RST_FONT_W = 7'd8;
   localparam logic [6:0]  RST_FONT_H = 7'd16;
   localparam logic [15:0] RST_SCR_W  = 16'd1024;
   localparam logic [15:0] RST_SCR_H  = 16'd768;
   localparam logic [23:0] RST_DEF_FG = 24'hD0D0D0;
   localparam logic [23:0] RST_DEF_BG = 24'h0D0F12;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_MOVE,
      KIND_TAB,
      KIND_SGR
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_TAB,
      ST_WRAP,
      ST_SCRL,
      ST_OUT1,
      ST_OUT2,
      ST_SGR_RD,
      ST_SGR_EX,
      ST_EXT_RD,
      ST_EXT_EX,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic div_step;
      logic tab;
      logic wrap;
      logic scroll_chk;
      logic emit_draw;
      logic emit_scroll;
      logic sgr_rd;
      logic sgr_ex;
      logic ext_rd;
      logic ext_ex;
      logic fin;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     div_done;
      logic     draw;
      logic     scroll;
      logic     out_free;
      logic     sgr_end;
      logic     ext_go;
      logic     ext_skip;
      logic     ext_last;
   } status_type;

   function automatic logic [31:0] palette(input logic [3:0] idx);
      logic [31:0] c;
      unique case (idx)
         4'd0:    c = 32'h00000000;
         4'd1:    c = 32'h00AA0000;
         4'd2:    c = 32'h0000AA00;
         4'd3:    c = 32'h00AA5500;
         4'd4:    c = 32'h000000AA;
         4'd5:    c = 32'h008C78B4;
         4'd6:    c = 32'h0000AAAA;
         4'd7:    c = 32'h00D0D0D0;
         4'd8:    c = 32'h00555555;
         4'd9:    c = 32'h00FF5555;
         4'd10:   c = 32'h0055FF55;
         4'd11:   c = 32'h00FFFF55;
         4'd12:   c = 32'h005555FF;
         4'd13:   c = 32'h00FF55FF;
         4'd14:   c = 32'h0055FFFF;
         default: c = 32'h00FFFFFF;
      endcase
      return c;
   endfunction

endpackage

/* src/atc_ctrl.sv */
// ----------------------------------------------------------------------------
// atc_ctrl
// Sequencer of the console: steps one transaction through decode, tab
// division, wrap, scroll, result output and the SGR parameter walk.
// ----------------------------------------------------------------------------
module atc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  atc_pkg::status_type st,
   output atc_pkg::cmd_type    cmd
);
   import atc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (st.kind)
               KIND_MOVE: state_in = ST_WRAP;
               KIND_TAB:  state_in = ST_DIV;
               KIND_SGR:  state_in = ST_SGR_RD;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_DIV: begin
            if (st.div_done) state_in = ST_TAB;
         end
         ST_TAB:  state_in = ST_WRAP;
         ST_WRAP: state_in = ST_SCRL;
         ST_SCRL: state_in = ST_OUT1;
         ST_OUT1: begin
            priority if (st.draw) begin
               if (st.out_free) state_in = st.scroll ? ST_OUT2 : ST_IDLE;
            end else if (st.scroll) begin
               state_in = ST_OUT2;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT2: begin
            if (st.out_free) state_in = ST_IDLE;
         end
         ST_SGR_RD: state_in = st.sgr_end ? ST_FIN : ST_SGR_EX;
         ST_SGR_EX: state_in = st.ext_go ? ST_EXT_RD : ST_SGR_RD;
         ST_EXT_RD: state_in = st.ext_skip ? ST_SGR_RD : ST_EXT_EX;
         ST_EXT_EX: state_in = st.ext_last ? ST_SGR_RD : ST_EXT_RD;
         ST_FIN:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DECODE: cmd.decode = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_TAB:    cmd.tab = 1'b1;
         ST_WRAP:   cmd.wrap = 1'b1;
         ST_SCRL:   cmd.scroll_chk = 1'b1;
         ST_OUT1:   cmd.emit_draw = st.draw & st.out_free;
         ST_OUT2:   cmd.emit_scroll = st.out_free;
         ST_SGR_RD: cmd.sgr_rd = 1'b1;
         ST_SGR_EX: cmd.sgr_ex = 1'b1;
         ST_EXT_RD: cmd.ext_rd = 1'b1;
         ST_EXT_EX: cmd.ext_ex = 1'b1;
         ST_FIN:    cmd.fin = 1'b1;
         default:   cmd = '0;
      endcase
   end

endmodule

/* src/atc_dp.sv */
// ----------------------------------------------------------------------------
// atc_dp
// Datapath of the console: cursor, colors, escape parser with parameter
// value memory, restoring divider for tabs and the result register.
// ----------------------------------------------------------------------------
module atc_dp #(
   parameter int BUFFER_BYTES = 32,
   parameter int MAX_PARAMS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  atc_pkg::cmd_type    cmd,
   output atc_pkg::status_type st,
   input  logic [6:0]         font_width,
   input  logic [6:0]         font_height,
   input  logic [15:0]        screen_width,
   input  logic [15:0]        screen_height,
   input  logic [23:0]        default_fg,
   input  logic [23:0]        default_bg,
   input  logic [2:0]         req_func,
   input  logic [7:0]         req_char_code,
   input  logic [31:0]        req_value,
   input  logic               req_fg_override_en,
   input  logic [30:0]        req_fg_override,
   input  logic               req_bg_override_en,
   input  logic [30:0]        req_bg_override,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_command,
   output logic [7:0]         rsp_glyph,
   output logic [15:0]        rsp_pos_x,
   output logic [15:0]        rsp_pos_y,
   output logic [31:0]        rsp_fg_colour,
   output logic [31:0]        rsp_bg_colour,
   output logic               rsp_last
);
   import atc_pkg::*;

   localparam int NW = $clog2(MAX_PARAMS + 1);
   localparam int AW = $clog2(MAX_PARAMS);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int IW = NW + 3;
   localparam logic [NW-1:0] NMAX = NW'(MAX_PARAMS);
   localparam logic [CW-1:0] BMAX = CW'(BUFFER_BYTES);

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] pcount_ff, pcount_in;
   logic [NW-1:0] pn_ff, pn_in;
   logic [15:0]   pv_ff, pv_in;
   logic          open_ff, open_in, halt_ff, halt_in;
   logic [15:0]   x_ff, x_in, y_ff, y_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0]   cfg_ff, cfg_in, cbg_ff, cbg_in, wfg_ff, wfg_in, wbg_ff, wbg_in;
   logic          ovr_ff, ovr_in;
   logic [2:0]    func_ff, func_in;
   logic [7:0]    char_ff, char_in;
   logic [15:0]   val_ff, val_in;
   logic          draw_ff, draw_in, scroll_ff, scroll_in;
   logic [15:0]   q_ff, q_in;
   logic [7:0]    rem_ff, rem_in;
   logic [3:0]    dcnt_ff, dcnt_in;
   logic [IW-1:0] i_ff, i_in;
   logic [2:0]    k_ff, k_in;
   logic          extfg_ff, extfg_in, sel_ff, sel_in;
   logic [7:0]    r_ff, r_in, g_ff, g_in;
   logic          rv_ff, rv_in, rcmd_ff, rcmd_in, rlast_ff, rlast_in;
   logic [7:0]    rgl_ff, rgl_in;
   logic [15:0]   rx_ff, rx_in, ry_ff, ry_in;
   logic [31:0]   rfg_ff, rfg_in, rbg_ff, rbg_in;

   logic [15:0]   mem [MAX_PARAMS];
   logic [15:0]   rdata_ff;
   logic          rzero_ff;
   logic          we;
   logic [AW-1:0] waddr;
   logic [15:0]   wdata;
   logic [IW-1:0] raddr;

   logic [6:0]    fw, fh;
   logic [NW-1:0] neff;
   logic [15:0]   v;
   logic [19:0]   vmul;
   logic [7:0]    trial;
   logic [16:0]   tnext;
   logic [23:0]   tprod;
   logic          out_free;
   logic [31:0]   dfg32, dbg32;
   logic [IW-1:0] iplus1, ik;

   assign fw = (font_width == 7'd0) ? 7'd1 : font_width;
   assign fh = (font_height == 7'd0) ? 7'd1 : font_height;
   assign neff = halt_ff ? NMAX : pn_ff;
   assign v = rzero_ff ? 16'd0 : rdata_ff;
   assign vmul = {4'd0, pv_ff} * 20'd10 + {16'd0, char_ff[3:0]};
   assign trial = {rem_ff[6:0], q_ff[15]};
   assign tnext = ({1'b0, q_ff} + 17'd8) & ~17'd7;
   assign tprod = {7'd0, tnext} * {17'd0, fw};
   assign out_free = !rv_ff || rsp_ready;
   assign dfg32 = {8'd0, default_fg};
   assign dbg32 = {8'd0, default_bg};
   assign iplus1 = i_ff + IW'(1);
   assign ik = i_ff + IW'(k_ff);

   always_comb begin
      st = '0;
      st.kind = KIND_NONE;
      if (func_ff == FUNC_PUT) begin
         priority if (char_ff == CH_ESC) begin
            st.kind = KIND_NONE;
         end else if (phase_ff == PH_ESC) begin
            st.kind = KIND_NONE;
         end else if (phase_ff != PH_NORMAL) begin
            st.kind = (char_ff == CH_SGR) ? KIND_SGR : KIND_NONE;
         end else if (char_ff == CH_TAB) begin
            st.kind = KIND_TAB;
         end else begin
            st.kind = KIND_MOVE;
         end
      end
      st.div_done = (dcnt_ff == 4'd15);
      st.draw     = draw_ff;
      st.scroll   = scroll_ff;
      st.out_free = out_free;
      st.sgr_end  = ({{(IW-NW){1'b0}}, neff} <= i_ff);
      st.ext_go   = (v == 16'd38 || v == 16'd48) && (iplus1 < {{(IW-NW){1'b0}}, neff});
      st.ext_skip = (ik >= {{(IW-NW){1'b0}}, neff});
      st.ext_last = (k_ff == 3'd4);
   end

   always_comb begin
      phase_in = phase_ff; pcount_in = pcount_ff; pn_in = pn_ff; pv_in = pv_ff;
      open_in = open_ff; halt_in = halt_ff; x_in = x_ff; y_in = y_ff;
      dx_in = dx_ff; dy_in = dy_ff; cfg_in = cfg_ff; cbg_in = cbg_ff;
      wfg_in = wfg_ff; wbg_in = wbg_ff; ovr_in = ovr_ff; func_in = func_ff;
      char_in = char_ff; val_in = val_ff; draw_in = draw_ff; scroll_in = scroll_ff;
      q_in = q_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; i_in = i_ff; k_in = k_ff;
      extfg_in = extfg_ff; sel_in = sel_ff; r_in = r_ff; g_in = g_ff;
      rv_in = rv_ff && !rsp_ready; rcmd_in = rcmd_ff; rlast_in = rlast_ff;
      rgl_in = rgl_ff; rx_in = rx_ff; ry_in = ry_ff; rfg_in = rfg_ff; rbg_in = rbg_ff;
      we = 1'b0; waddr = pn_ff[AW-1:0]; wdata = pv_ff;
      raddr = i_ff;

      if (cmd.load) begin
         func_in = req_func;
         char_in = req_char_code;
         val_in  = req_value[15:0];
         ovr_in  = req_fg_override_en | req_bg_override_en;
         wfg_in  = req_fg_override_en ? {1'b0, req_fg_override} : cfg_ff;
         wbg_in  = req_bg_override_en ? {1'b0, req_bg_override} : cbg_ff;
         if (req_func == FUNC_FG) cfg_in = req_value;
         if (req_func == FUNC_BG) cbg_in = req_value;
         draw_in = 1'b0;
      end

      if (cmd.decode) begin
         if (func_ff == FUNC_X) x_in = val_ff;
         if (func_ff == FUNC_Y) y_in = val_ff;
         if (func_ff == FUNC_PUT) begin
            priority if (char_ff == CH_ESC) begin
               phase_in = PH_ESC;
            end else if (phase_ff == PH_ESC) begin
               if (char_ff == CH_LBR) begin
                  phase_in = PH_SEQ; pcount_in = '0; pn_in = '0;
                  open_in = 1'b0; halt_in = 1'b0;
               end else begin
                  phase_in = PH_NORMAL;
               end
            end else if (phase_ff != PH_NORMAL) begin
               if (char_ff >= 8'h30 && char_ff <= 8'h3F) begin
                  if (pcount_ff < BMAX) begin
                     pcount_in = pcount_ff + CW'(1);
                     if (!halt_ff) begin
                        if (open_ff) begin
                           if (char_ff <= 8'h39) begin
                              pv_in = (vmul > 20'd65535) ? 16'hFFFF : vmul[15:0];
                           end else begin
                              we = 1'b1; pn_in = pn_ff + NW'(1); open_in = 1'b0;
                              if (char_ff != CH_SEMI) halt_in = 1'b1;
                           end
                        end else if (pn_ff < NMAX) begin
                           if (char_ff <= 8'h39) begin
                              open_in = 1'b1; pv_in = {12'd0, char_ff[3:0]};
                           end else if (char_ff == CH_SEMI) begin
                              we = 1'b1; wdata = 16'd0; pn_in = pn_ff + NW'(1);
                           end else begin
                              halt_in = 1'b1;
                           end
                        end
                     end
                  end
               end else if (char_ff >= 8'h40 && char_ff <= 8'h7E) begin
                  phase_in = PH_NORMAL; pcount_in = '0;
                  if (char_ff == CH_SGR) begin
                     i_in = '0;
                     if (open_ff) begin
                        we = 1'b1; pn_in = pn_ff + NW'(1); open_in = 1'b0;
                     end
                  end
               end
            end else if (char_ff == CH_NL) begin
               x_in = 16'd0; y_in = y_ff + {9'd0, fh};
            end else if (char_ff == CH_CR) begin
               x_in = 16'd0;
            end else if (char_ff == CH_TAB) begin
               q_in = x_ff; rem_in = 8'd0; dcnt_in = 4'd0;
            end else begin
               draw_in = 1'b1; dx_in = x_ff; dy_in = y_ff;
               x_in = x_ff + {9'd0, fw};
            end
         end
      end

      if (cmd.div_step) begin
         dcnt_in = dcnt_ff + 4'd1;
         if (trial >= {1'b0, fw}) begin
            rem_in = trial - {1'b0, fw}; q_in = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial; q_in = {q_ff[14:0], 1'b0};
         end
      end

      if (cmd.tab) x_in = tprod[15:0];

      if (cmd.wrap) begin
         if ({1'b0, x_ff} + {10'd0, fw} > {1'b0, screen_width}) begin
            x_in = 16'd0; y_in = y_ff + {9'd0, fh};
         end
      end

      if (cmd.scroll_chk) begin
         scroll_in = ({1'b0, y_ff} + {10'd0, fh} > {1'b0, screen_height});
         if (scroll_in) y_in = y_ff - {9'd0, fh};
      end

      if (cmd.emit_draw) begin
         rv_in = 1'b1; rcmd_in = 1'b0; rgl_in = char_ff; rx_in = dx_ff; ry_in = dy_ff;
         rfg_in = wfg_ff; rbg_in = wbg_ff; rlast_in = !scroll_ff;
      end
      if (cmd.emit_scroll) begin
         rv_in = 1'b1; rcmd_in = 1'b1; rgl_in = 8'd0; rx_in = 16'd0; ry_in = 16'd0;
         rfg_in = 32'd0; rbg_in = wbg_ff; rlast_in = 1'b1;
      end

      if (cmd.sgr_rd && neff == '0) begin
         wfg_in = dfg32; wbg_in = dbg32;
      end

      if (cmd.sgr_ex) begin
         if (st.ext_go) begin
            k_in = 3'd1; extfg_in = (v == 16'd38);
         end else begin
            i_in = iplus1;
            priority if (v == 16'd0) begin
               wfg_in = dfg32; wbg_in = dbg32;
            end else if (v >= 16'd30 && v <= 16'd37) begin
               wfg_in = palette({1'b0, v[2:0] - 3'd6});
            end else if (v == 16'd39) begin
               wfg_in = dfg32;
            end else if (v >= 16'd40 && v <= 16'd47) begin
               wbg_in = palette({1'b0, v[2:0]});
            end else if (v == 16'd49) begin
               wbg_in = dbg32;
            end else if (v >= 16'd90 && v <= 16'd97) begin
               wfg_in = palette({1'b1, v[2:0] - 3'd2});
            end else if (v >= 16'd100 && v <= 16'd107) begin
               wbg_in = palette({1'b1, v[2:0] - 3'd4});
            end else begin
               wfg_in = wfg_ff;
            end
         end
      end

      if (cmd.ext_rd) begin
         raddr = ik;
         if (st.ext_skip) i_in = i_ff + IW'(5);
      end

      if (cmd.ext_ex) begin
         k_in = k_ff + 3'd1;
         unique case (k_ff)
            3'd1:    sel_in = (v[7:0] == 8'd2);
            3'd2:    r_in = v[7:0];
            3'd3:    g_in = v[7:0];
            default: begin
               i_in = i_ff + IW'(5);
               if (sel_ff) begin
                  if (extfg_ff) wfg_in = {8'd0, r_ff, g_ff, v[7:0]};
                  else          wbg_in = {8'd0, r_ff, g_ff, v[7:0]};
               end
            end
         endcase
      end

      if (cmd.fin && !ovr_ff) begin
         cfg_in = wfg_ff; cbg_in = wbg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr[AW-1:0]];
      rzero_ff <= (raddr >= {{(IW-NW){1'b0}}, pn_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NORMAL; pcount_ff <= '0; pn_ff <= '0; open_ff <= 1'b0;
         halt_ff <= 1'b0; x_ff <= 16'd0; y_ff <= 16'd0;
         cfg_ff <= {8'd0, RST_DEF_FG}; cbg_ff <= {8'd0, RST_DEF_BG};
         rv_ff <= 1'b0; draw_ff <= 1'b0; scroll_ff <= 1'b0;
         func_ff <= FUNC_PUT; char_ff <= 8'd0; dcnt_ff <= 4'd0;
         i_ff <= '0; k_ff <= 3'd0;
      end else begin
         phase_ff <= phase_in; pcount_ff <= pcount_in; pn_ff <= pn_in; open_ff <= open_in;
         halt_ff <= halt_in; x_ff <= x_in; y_ff <= y_in;
         cfg_ff <= cfg_in; cbg_ff <= cbg_in;
         rv_ff <= rv_in; draw_ff <= draw_in; scroll_ff <= scroll_in;
         func_ff <= func_in; char_ff <= char_in; dcnt_ff <= dcnt_in;
         i_ff <= i_in; k_ff <= k_in;
      end
      pv_ff <= pv_in; dx_ff <= dx_in; dy_ff <= dy_in; wfg_ff <= wfg_in; wbg_ff <= wbg_in;
      ovr_ff <= ovr_in; val_ff <= val_in; q_ff <= q_in; rem_ff <= rem_in;
      extfg_ff <= extfg_in; sel_ff <= sel_in; r_ff <= r_in; g_ff <= g_in;
      rcmd_ff <= rcmd_in; rlast_ff <= rlast_in; rgl_ff <= rgl_in; rx_ff <= rx_in;
      ry_ff <= ry_in; rfg_ff <= rfg_in; rbg_ff <= rbg_in;
   end

   assign rsp_valid     = rv_ff;
   assign rsp_command   = rcmd_ff;
   assign rsp_glyph     = rgl_ff;
   assign rsp_pos_x     = rx_ff;
   assign rsp_pos_y     = ry_ff;
   assign rsp_fg_colour = rfg_ff;
   assign rsp_bg_colour = rbg_ff;
   assign rsp_last      = rlast_ff;

endmodule

/* src/ansi_text_console.sv */
// ----------------------------------------------------------------------------
// ansi_text_console
// Text console with ANSI escape parsing and SGR colors, driving draw and
// scroll commands from a byte stream.
// ----------------------------------------------------------------------------
// Tabs run a 16-step divider; an SGR final byte walks its parameter codes in
//   turn, reading extended color codes element by element.
// One transaction at a time: req_ready is high only while idle, and output
//   waits while the result register is full; that register holds a result
//   while the next transaction is taken.
// Reset: synchronous; cursor home, normal state, registers to defaults.
module ansi_text_console #(
   parameter int BUFFER_BYTES = 32,
   parameter int MAX_PARAMS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [7:0]  req_char_code,
   input  logic [31:0] req_value,
   input  logic        req_fg_override_en,
   input  logic [30:0] req_fg_override,
   input  logic        req_bg_override_en,
   input  logic [30:0] req_bg_override,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_command,
   output logic [7:0]  rsp_glyph,
   output logic [15:0] rsp_pos_x,
   output logic [15:0] rsp_pos_y,
   output logic [31:0] rsp_fg_colour,
   output logic [31:0] rsp_bg_colour,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import atc_pkg::*;

   cmd_type    cmd;
   status_type st;

   logic [6:0]  fw_ff, fh_ff;
   logic [15:0] sw_ff, sh_ff;
   logic [23:0] dfg_ff, dbg_ff;
   logic        wr;
   logic [2:0]  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= RST_FONT_W; fh_ff <= RST_FONT_H; sw_ff <= RST_SCR_W;
         sh_ff <= RST_SCR_H; dfg_ff <= RST_DEF_FG; dbg_ff <= RST_DEF_BG;
      end else if (wr) begin
         unique case (idx)
            REG_FONT_W: fw_ff <= csr_pwdata[6:0];
            REG_FONT_H: fh_ff <= csr_pwdata[6:0];
            REG_SCR_W:  sw_ff <= csr_pwdata[15:0];
            REG_SCR_H:  sh_ff <= csr_pwdata[15:0];
            REG_DEF_FG: dfg_ff <= csr_pwdata[23:0];
            REG_DEF_BG: dbg_ff <= csr_pwdata[23:0];
            default:    fw_ff <= fw_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_FONT_W: csr_prdata = {25'd0, fw_ff};
         REG_FONT_H: csr_prdata = {25'd0, fh_ff};
         REG_SCR_W:  csr_prdata = {16'd0, sw_ff};
         REG_SCR_H:  csr_prdata = {16'd0, sh_ff};
         REG_DEF_FG: csr_prdata = {8'd0, dfg_ff};
         REG_DEF_BG: csr_prdata = {8'd0, dbg_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   atc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   atc_dp #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .MAX_PARAMS   (MAX_PARAMS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .font_width         (fw_ff),
      .font_height        (fh_ff),
      .screen_width       (sw_ff),
      .screen_height      (sh_ff),
      .default_fg         (dfg_ff),
      .default_bg         (dbg_ff),
      .req_func           (req_func),
      .req_char_code      (req_char_code),
      .req_value          (req_value),
      .req_fg_override_en (req_fg_override_en),
      .req_fg_override    (req_fg_override),
      .req_bg_override_en (req_bg_override_en),
      .req_bg_override    (req_bg_override),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_command        (rsp_command),
      .rsp_glyph          (rsp_glyph),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_fg_colour      (rsp_fg_colour),
      .rsp_bg_colour      (rsp_bg_colour),
      .rsp_last           (rsp_last)
   );

endmodule

/* tb/ansi_text_console_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_text_console_tb
// Drives byte, cursor and color transactions into the console with bursty
// input and stalled output, predicts draw and scroll results, and compares
// every result field against the prediction. Registers change between phases.
// ----------------------------------------------------------------------------
module ansi_text_console_tb;
   import atc_pkg::*;

   class console_scoreboard;
      localparam int BUFFER_LEN = 32;
      localparam int CODE_LIMIT = 32;

      logic [6:0]   font_w;
      logic [6:0]   font_h;
      logic [15:0]  scr_w;
      logic [15:0]  scr_h;
      logic [23:0]  def_fg;
      logic [23:0]  def_bg;
      logic [1:0]   phase;
      logic [7:0]   seq_buf[BUFFER_LEN];
      int           seq_len;
      logic [15:0]  cur_x;
      logic [15:0]  cur_y;
      logic [31:0]  cur_fg;
      logic [31:0]  cur_bg;
      logic [105:0] pending[$];
      int           errors;

      function new();
         font_w = RST_FONT_W;
         font_h = RST_FONT_H;
         scr_w = RST_SCR_W;
         scr_h = RST_SCR_H;
         def_fg = RST_DEF_FG;
         def_bg = RST_DEF_BG;
         phase = PH_NORMAL;
         seq_len = 0;
         cur_x = 0;
         cur_y = 0;
         cur_fg = {8'h0, RST_DEF_FG};
         cur_bg = {8'h0, RST_DEF_BG};
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            REG_FONT_W: font_w = v[6:0];
            REG_FONT_H: font_h = v[6:0];
            REG_SCR_W:  scr_w = v[15:0];
            REG_SCR_H:  scr_h = v[15:0];
            REG_DEF_FG: def_fg = v[23:0];
            REG_DEF_BG: def_bg = v[23:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] color_of(int idx);
         logic [31:0] t[16];
         t = '{32'h0, 32'hAA0000, 32'h00AA00, 32'hAA5500, 32'h0000AA, 32'h8C78B4,
               32'h00AAAA, 32'hD0D0D0, 32'h555555, 32'hFF5555, 32'h55FF55,
               32'hFFFF55, 32'h5555FF, 32'hFF55FF, 32'h55FFFF, 32'hFFFFFF};
         return t[idx];
      endfunction

      function void apply_sgr();
         int codes[CODE_LIMIT];
         int n;
         int p;
         int i;
         int v;
         n = 0;
         p = 0;
         while (p < seq_len && n < CODE_LIMIT) begin
            v = 0;
            while (p < seq_len && seq_buf[p] >= "0" && seq_buf[p] <= "9") begin
               v = v * 10 + (seq_buf[p] - "0");
               if (v > 65535) v = 65535;
               p++;
            end
            codes[n++] = v;
            if (p < seq_len && seq_buf[p] == CH_SEMI) p++;
         end
         if (n == 0) begin
            cur_fg = {8'h0, def_fg};
            cur_bg = {8'h0, def_bg};
            return;
         end
         i = 0;
         while (i < n) begin
            v = codes[i];
            if (v == 0) begin
               cur_fg = {8'h0, def_fg};
               cur_bg = {8'h0, def_bg};
            end else if (v >= 30 && v <= 37) cur_fg = color_of(v - 30);
            else if (v == 39) cur_fg = {8'h0, def_fg};
            else if (v >= 40 && v <= 47) cur_bg = color_of(v - 40);
            else if (v == 49) cur_bg = {8'h0, def_bg};
            else if (v >= 90 && v <= 97) cur_fg = color_of(v - 82);
            else if (v >= 100 && v <= 107) cur_bg = color_of(v - 92);
            else if ((v == 38 || v == 48) && i + 1 < n) begin
               if ((codes[i + 1] & 255) == 2 && i + 4 < n) begin
                  if (v == 38)
                     cur_fg = {8'h0, 8'(codes[i + 2]), 8'(codes[i + 3]), 8'(codes[i + 4])};
                  else
                     cur_bg = {8'h0, 8'(codes[i + 2]), 8'(codes[i + 3]), 8'(codes[i + 4])};
               end
               i += 4;
            end
            i++;
         end
      endfunction

      function void push(logic cmd, logic [7:0] g, logic [15:0] x, logic [15:0] y,
                         logic [31:0] fg, logic [31:0] bg);
         pending.push_back({cmd, g, x, y, fg, bg, 1'b1});
      endfunction

      function void feed_byte(logic [7:0] c);
         logic [16:0] fw;
         logic [16:0] fh;
         int          k;
         logic [31:0] nx;
         fw = (font_w == 7'd0) ? 17'd1 : {10'd0, font_w};
         fh = (font_h == 7'd0) ? 17'd1 : {10'd0, font_h};
         k = 0;
         if (c == CH_ESC) begin
            phase = PH_ESC;
            return;
         end
         if (phase == PH_ESC) begin
            if (c == CH_LBR) begin
               phase = PH_SEQ;
               seq_len = 0;
            end else phase = PH_NORMAL;
            return;
         end
         if (phase != PH_NORMAL) begin
            if (c >= 8'h30 && c <= 8'h3F) begin
               if (seq_len < BUFFER_LEN) seq_buf[seq_len++] = c;
            end else if (c >= 8'h40 && c <= 8'h7E) begin
               if (c == CH_SGR) apply_sgr();
               phase = PH_NORMAL;
               seq_len = 0;
            end
            return;
         end
         if (c == CH_NL) begin
            cur_x = 0;
            cur_y = 16'(cur_y + fh);
         end else if (c == CH_CR) cur_x = 0;
         else if (c == CH_TAB) begin
            nx = ((32'(cur_x) / fw) + 8) & ~32'd7;
            cur_x = 16'(nx * fw);
         end else begin
            push(1'b0, c, cur_x, cur_y, cur_fg, cur_bg);
            k++;
            cur_x = 16'(cur_x + fw);
         end
         if (32'(cur_x) + fw > scr_w) begin
            cur_x = 0;
            cur_y = 16'(cur_y + fh);
         end
         if (32'(cur_y) + fh > scr_h) begin
            if (k > 0) pending[$][0] = 1'b0;
            push(1'b1, 8'h0, 16'h0, 16'h0, 32'h0, cur_bg);
            cur_y = 16'(cur_y - fh);
         end
      endfunction

      function void note_request(logic [2:0] f, logic [7:0] c, logic [31:0] v,
                                 logic fo, logic [30:0] fov, logic bo, logic [30:0] bov);
         logic [31:0] sfg;
         logic [31:0] sbg;
         case (f)
            FUNC_PUT: begin
               sfg = cur_fg;
               sbg = cur_bg;
               if (fo) cur_fg = {1'b0, fov};
               if (bo) cur_bg = {1'b0, bov};
               feed_byte(c);
               if (fo || bo) begin
                  cur_fg = sfg;
                  cur_bg = sbg;
               end
            end
            FUNC_X:  cur_x = v[15:0];
            FUNC_Y:  cur_y = v[15:0];
            FUNC_FG: cur_fg = v;
            FUNC_BG: cur_bg = v;
            default: ;
         endcase
      endfunction

      function void check_result(logic cmd, logic [7:0] g, logic [15:0] x, logic [15:0] y,
                                 logic [31:0] fg, logic [31:0] bg, logic lst);
         logic [105:0] e;
         if (pending.size() == 0) begin
            $error("unexpected result command=%0d glyph=%h", cmd, g);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e[105] !== cmd) begin
            $error("command expected %0d actual %0d", e[105], cmd);
            errors++;
         end
         if (e[104:97] !== g) begin
            $error("glyph expected %h actual %h", e[104:97], g);
            errors++;
         end
         if (e[96:81] !== x) begin
            $error("pos_x expected %0d actual %0d", e[96:81], x);
            errors++;
         end
         if (e[80:65] !== y) begin
            $error("pos_y expected %0d actual %0d", e[80:65], y);
            errors++;
         end
         if (e[64:33] !== fg) begin
            $error("fg_colour expected %h actual %h", e[64:33], fg);
            errors++;
         end
         if (e[32:1] !== bg) begin
            $error("bg_colour expected %h actual %h", e[32:1], bg);
            errors++;
         end
         if (e[0] !== lst) begin
            $error("last expected %0d actual %0d", e[0], lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_func = 0;
   logic [7:0]  req_char_code = 0;
   logic [31:0] req_value = 0;
   logic        req_fg_override_en = 0;
   logic [30:0] req_fg_override = 0;
   logic        req_bg_override_en = 0;
   logic [30:0] req_bg_override = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_command;
   logic [7:0]  rsp_glyph;
   logic [15:0] rsp_pos_x;
   logic [15:0] rsp_pos_y;
   logic [31:0] rsp_fg_colour;
   logic [31:0] rsp_bg_colour;
   logic        rsp_last;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [4:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   console_scoreboard board;
   int idle_cycles;
   int stall_mode;
   int burst_left;

   always #6 clock = ~clock;

   ansi_text_console dut (.*);

   // receiver: mode selects always-ready, light or heavy stalls
   always @(posedge clock) begin
      if (stall_mode == 0) rsp_ready <= 1'b1;
      else if (stall_mode == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
      else rsp_ready <= ($urandom_range(0, 3) == 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_result(rsp_command, rsp_glyph, rsp_pos_x, rsp_pos_y,
                            rsp_fg_colour, rsp_bg_colour, rsp_last);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.write_reg(idx, v);
      @(posedge clock);
   endtask

   task automatic send(logic [2:0] f, logic [7:0] c, logic [31:0] v,
                       logic fo, logic [30:0] fov, logic bo, logic [30:0] bov);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= f;
      req_char_code <= c;
      req_value <= v;
      req_fg_override_en <= fo;
      req_fg_override <= fov;
      req_bg_override_en <= bo;
      req_bg_override <= bov;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(f, c, v, fo, fov, bo, bov);
   endtask

   task automatic put(logic [7:0] c);
      send(FUNC_PUT, c, 32'h0, 1'b0, 31'h0, 1'b0, 31'h0);
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_sgr();
      int n;
      int r;
      put(CH_ESC);
      put(CH_LBR);
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r < 3) put_text($sformatf("%0d", $urandom_range(30, 49)));
         else if (r < 5) put_text($sformatf("%0d", $urandom_range(90, 107)));
         else if (r == 5)
            put_text($sformatf("%0d;2;%0d;%0d;%0d", $urandom_range(0, 1) ? 38 : 48,
                     $urandom_range(0, 999), $urandom_range(0, 300), $urandom_range(0, 99999)));
         else if (r == 6) put_text($sformatf("%0d", $urandom_range(0, 99999)));
         else if (r == 7) put(8'($urandom_range(8'h3C, 8'h3F)));
         else put_text($sformatf("%0d", $urandom_range(0, 9)));
         if (i + 1 < n) put(CH_SEMI);
      end
      r = $urandom_range(0, 9);
      if (r < 8) put(CH_SGR);
      else if (r == 8) put(8'($urandom_range(8'h40, 8'h7E)));
      else put(CH_ESC);
   endtask

   task automatic random_item();
      int r;
      logic [7:0] c;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         c = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7E));
         if ($urandom_range(0, 4) == 0) c = CH_NL;
         else if ($urandom_range(0, 5) == 0) c = CH_TAB;
         else if ($urandom_range(0, 9) == 0) c = CH_CR;
         send(FUNC_PUT, c, $urandom, $urandom_range(0, 4) == 0, 31'($urandom),
              $urandom_range(0, 4) == 0, 31'($urandom));
      end else if (r < 75) random_sgr();
      else if (r < 80)
         send(FUNC_PUT, CH_ESC, 32'h0, 1'b0, 31'h0, 1'b0, 31'h0);
      else if (r < 85) send(FUNC_X, 8'($urandom), $urandom_range(0, 1) ? $urandom
                           : $urandom_range(0, 1100), 1'b0, 31'h0, 1'b0, 31'h0);
      else if (r < 90) send(FUNC_Y, 8'($urandom), $urandom_range(0, 1) ? $urandom
                           : $urandom_range(0, 800), 1'b0, 31'h0, 1'b0, 31'h0);
      else if (r < 94) send(FUNC_FG, 8'($urandom), $urandom, 1'b0, 31'h0, 1'b0, 31'h0);
      else if (r < 98) send(FUNC_BG, 8'($urandom), $urandom, 1'b0, 31'h0, 1'b0, 31'h0);
      else send(3'($urandom_range(5, 7)), 8'($urandom), $urandom,
                1'($urandom_range(0, 1)), 31'($urandom), 1'($urandom_range(0, 1)),
                31'($urandom));
   endtask

   initial begin
      board = new();
      idle_cycles = 0;
      stall_mode = 0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      put_text("A\t\r\n");
      put(8'hFF);
      put(8'h00);
      send(FUNC_PUT, "Z", 32'h0, 1'b1, 31'h7FFFFFFF, 1'b1, 31'h0);
      send(FUNC_X, 8'h0, 32'hFFFF_03F8, 1'b0, 31'h0, 1'b0, 31'h0);
      put("W");
      send(FUNC_Y, 8'h0, 32'd752, 1'b0, 31'h0, 1'b0, 31'h0);
      put(CH_NL);
      put_text("\033[m");
      put_text("\033[31;102;38;2;300;17;65;48;2;1m");
      put_text("\033[99999;39;49;0;97m");
      put_text("\033x\033\033[5q");
      send(FUNC_PUT, "q", 32'h0, 1'b0, 31'h0, 1'b1, 31'h1234567);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         stall_mode = ph % 3;
         case (ph)
            0: begin
               csr_write(REG_FONT_W, 32'd1); csr_write(REG_FONT_H, 32'd1);
               csr_write(REG_SCR_W, 32'd1); csr_write(REG_SCR_H, 32'd1);
            end
            1: begin
               csr_write(REG_FONT_W, 32'd64); csr_write(REG_FONT_H, 32'd64);
               csr_write(REG_SCR_W, 32'd65535); csr_write(REG_SCR_H, 32'd65535);
               csr_write(REG_DEF_FG, 32'hFFFFFF); csr_write(REG_DEF_BG, 32'h0);
            end
            2: begin
               csr_write(REG_FONT_W, 32'd0); csr_write(REG_FONT_H, 32'd0);
               csr_write(REG_SCR_W, 32'd40); csr_write(REG_SCR_H, 32'd30);
               csr_write(REG_DEF_FG, 32'h0); csr_write(REG_DEF_BG, 32'hFFFFFF);
            end
            default: begin
               csr_write(REG_FONT_W, $urandom_range(1, 64));
               csr_write(REG_FONT_H, $urandom_range(1, 64));
               csr_write(REG_SCR_W, $urandom_range(1, 1200));
               csr_write(REG_SCR_H, $urandom_range(1, 900));
               csr_write(REG_DEF_FG, $urandom);
               csr_write(REG_DEF_BG, $urandom);
            end
         endcase
         for (int i = 0; i < 62; i++) random_item();
         drain();
      end

      if (board.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
